FILE: rtl/mmcd_pkg.sv
`timescale 1ns / 1ps

package mmcd_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int INDEX_BITS    = 16;
   localparam int BIN_REG_BITS  = 17;
   localparam int COL_REG_BITS  = 13;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam int DEF_MAX_BINS    = 65536;
   localparam int DEF_MAX_COLUMNS = 4096;

   localparam int RST_BIN_COUNT     = 4096;
   localparam int RST_PIXEL_COLUMNS = 1024;

   typedef enum logic {
      REG_BIN_COUNT     = 1'b0,
      REG_PIXEL_COLUMNS = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]         bin_index;
      logic signed [SAMPLE_BITS-1:0] point_value;
      logic                          run_last;
      logic                          frame_end;
   } point_type;

   typedef struct packed {
      logic      pair;
      point_type first;
      point_type second;
   } bundle_type;

endpackage

FILE: rtl/minmax_column_decimator.sv
`timescale 1ns / 1ps
// Channel   Ports                              Direction  Moves
// request   req_valid/req_ready/req_*          in         one sample per request
// response  rsp_valid/rsp_ready/rsp_*          out        one point per response
// config    psel/penable/pwrite/paddr/pwdata   in         bin_count at 0, pixel_columns at 4
//
// One request per cycle while req_ready is high. An accepted sample enters the
// two-entry result queue in the cycle after acceptance; a column end gives two points,
// drained one per cycle from the queue while rsp_ready is high. A register write aborts
// the frame and starts a bit-serial divider for the column step; req_ready stays low
// until the divider is done. Reset loads the default step directly: no clearing pass.
// req_ready drops while the queue holds two entries.

module minmax_column_decimator
   import mmcd_pkg::*;
#(
   parameter int MAX_BINS    = DEF_MAX_BINS,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [INDEX_BITS-1:0]         rsp_bin_index,
   output logic signed [SAMPLE_BITS-1:0] rsp_point_value,
   output logic                          rsp_run_last,
   output logic                          rsp_frame_end,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      paddr,
   input  logic [CSR_DATA_BITS-1:0]      pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   localparam int BIN_REG_MAX = (1 << BIN_REG_BITS) - 1;
   localparam int COL_REG_MAX = (1 << COL_REG_BITS) - 1;
   localparam int EFF_MAX_B   = (MAX_BINS < BIN_REG_MAX) ? MAX_BINS : BIN_REG_MAX;
   localparam int EFF_MAX_C   = (MAX_COLUMNS < COL_REG_MAX) ? MAX_COLUMNS : COL_REG_MAX;
   localparam int BW          = $clog2(EFF_MAX_B + 1);
   localparam int CW          = $clog2(EFF_MAX_C + 1);
   localparam int CMP_W       = ((BW > CW + 1) ? BW : CW + 1) + 1;
   localparam int DCW         = $clog2(BW + 1);
   localparam int RST_B       = (RST_BIN_COUNT < EFF_MAX_B) ? RST_BIN_COUNT : EFF_MAX_B;
   localparam int RST_C       = (RST_PIXEL_COLUMNS < EFF_MAX_C) ? RST_PIXEL_COLUMNS : EFF_MAX_C;
   localparam int RST_Q       = RST_B / RST_C;
   localparam int RST_R       = RST_B % RST_C;

   localparam logic [BIN_REG_BITS-1:0] MAX_B_REG = BIN_REG_BITS'(EFF_MAX_B);
   localparam logic [COL_REG_BITS-1:0] MAX_C_REG = COL_REG_BITS'(EFF_MAX_C);

   logic [BIN_REG_BITS-1:0] bin_count_ff, bin_count_in;
   logic [COL_REG_BITS-1:0] pixel_columns_ff, pixel_columns_in;
   logic [BW-1:0]           eff_b;
   logic [CW-1:0]           eff_c;
   logic                    csr_write;

   logic                    div_start_ff, div_start_in;
   logic                    div_busy_ff, div_busy_in;
   logic [DCW-1:0]          div_cnt_ff, div_cnt_in;
   logic [CW-1:0]           div_rem_ff, div_rem_in;
   logic [BW-1:0]           div_quo_ff, div_quo_in;
   logic [CW-1:0]           div_den_ff, div_den_in;
   logic [CW:0]             div_shift;
   logic                    div_bit;

   logic [BW-1:0]           bin_cnt_ff, bin_cnt_in;
   logic [BW-1:0]           col_end_ff, col_end_in;
   logic [CW-1:0]           bnd_rem_ff, bnd_rem_in;
   logic [BW-1:0]           step_q_ff, step_q_in;
   logic [CW-1:0]           step_r_ff, step_r_in;
   logic signed [SAMPLE_BITS-1:0] run_min_ff, run_min_in;
   logic signed [SAMPLE_BITS-1:0] run_max_ff, run_max_in;
   logic [BW-1:0]           min_pos_ff, min_pos_in;
   logic [BW-1:0]           max_pos_ff, max_pos_in;

   logic                    take;
   logic                    run_zero;
   logic                    pass_mode;
   logic                    fend;
   logic                    col_done;
   logic                    push;
   logic [BW:0]             i_inc;
   logic [BW:0]             ce_add;
   logic [CW:0]             rem_add;
   logic                    rem_wrap;
   bundle_type              bundle;

   bundle_type              queue_ff [2];
   logic [1:0]              count_ff, count_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    sub_ff, sub_in;
   bundle_type              head;
   point_type               head_point;
   logic                    pop_out;
   logic                    bundle_done;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   assign eff_b = (bin_count_ff > MAX_B_REG) ? BW'(EFF_MAX_B) : BW'(bin_count_ff);
   assign eff_c = (pixel_columns_ff > MAX_C_REG) ? CW'(EFF_MAX_C) : CW'(pixel_columns_ff);

   always_comb begin
      bin_count_in     = bin_count_ff;
      pixel_columns_in = pixel_columns_ff;
      if (csr_write) begin
         case (csr_reg_type'(paddr[2]))
            REG_BIN_COUNT:     bin_count_in     = pwdata[BIN_REG_BITS-1:0];
            REG_PIXEL_COLUMNS: pixel_columns_in = pwdata[COL_REG_BITS-1:0];
            default:           bin_count_in     = bin_count_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(paddr[2]))
         REG_BIN_COUNT:     prdata = CSR_DATA_BITS'(bin_count_ff);
         REG_PIXEL_COLUMNS: prdata = CSR_DATA_BITS'(pixel_columns_ff);
         default:           prdata = '0;
      endcase
   end

   assign div_shift = {div_rem_ff, div_quo_ff[BW-1]};
   assign div_bit   = (div_shift >= {1'b0, div_den_ff});

   always_comb begin
      div_start_in = csr_write;
      div_busy_in  = div_busy_ff;
      div_cnt_in   = div_cnt_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_den_in   = div_den_ff;
      step_q_in    = step_q_ff;
      step_r_in    = step_r_ff;
      if (div_start_ff) begin
         div_busy_in = 1'b1;
         div_cnt_in  = '0;
         div_rem_in  = '0;
         div_quo_in  = eff_b;
         div_den_in  = eff_c;
      end else if (div_busy_ff) begin
         div_rem_in = div_bit ? CW'(div_shift - {1'b0, div_den_ff}) : div_shift[CW-1:0];
         div_quo_in = {div_quo_ff[BW-2:0], div_bit};
         div_cnt_in = div_cnt_ff + 1'b1;
         if (div_cnt_ff == DCW'(BW - 1)) begin
            div_busy_in = 1'b0;
            step_q_in   = (div_den_ff == '0) ? '0 : div_quo_in;
            step_r_in   = (div_den_ff == '0) ? '0 : div_rem_in;
         end
      end
      if (csr_write) begin
         div_busy_in = 1'b0;
      end
   end

   assign req_ready = (count_ff != 2'd2) && !div_start_ff && !div_busy_ff;
   assign take      = req_valid && req_ready;
   assign run_zero  = (eff_b == '0) || (eff_c == '0);
   assign i_inc     = {1'b0, bin_cnt_ff} + 1'b1;
   assign fend      = (i_inc >= {1'b0, eff_b});
   assign pass_mode = (CMP_W'({eff_c, 1'b0}) >= CMP_W'(eff_b));
   assign ce_add    = {1'b0, col_end_ff} + {1'b0, step_q_ff};
   assign rem_add   = {1'b0, bnd_rem_ff} + {1'b0, step_r_ff};
   assign rem_wrap  = (rem_add >= {1'b0, eff_c});

   always_comb begin
      bin_cnt_in = bin_cnt_ff;
      col_end_in = col_end_ff;
      bnd_rem_in = bnd_rem_ff;
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      min_pos_in = min_pos_ff;
      max_pos_in = max_pos_ff;
      if (take && !run_zero) begin
         bin_cnt_in = fend ? '0 : i_inc[BW-1:0];
         if (!pass_mode) begin
            if (bin_cnt_ff == '0 || bin_cnt_ff >= col_end_ff) begin
               if (bin_cnt_ff == '0) begin
                  col_end_in = step_q_ff;
                  bnd_rem_in = step_r_ff;
               end else begin
                  col_end_in = ce_add[BW-1:0] + BW'(rem_wrap);
                  bnd_rem_in = rem_wrap ? CW'(rem_add - {1'b0, eff_c}) : rem_add[CW-1:0];
               end
               run_min_in = req_sample_value;
               run_max_in = req_sample_value;
               min_pos_in = bin_cnt_ff;
               max_pos_in = bin_cnt_ff;
            end else begin
               if (req_sample_value < run_min_ff) begin
                  run_min_in = req_sample_value;
                  min_pos_in = bin_cnt_ff;
               end
               if (req_sample_value > run_max_ff) begin
                  run_max_in = req_sample_value;
                  max_pos_in = bin_cnt_ff;
               end
            end
         end
      end
      if (csr_write) begin
         bin_cnt_in = '0;
      end
   end

   assign col_done = (i_inc == {1'b0, col_end_in}) || fend;
   assign push     = take && !run_zero && (pass_mode || col_done);

   always_comb begin
      bundle = '0;
      if (pass_mode) begin
         bundle.pair   = 1'b0;
         bundle.first  = '{INDEX_BITS'(bin_cnt_ff), req_sample_value, 1'b1, fend};
         bundle.second = bundle.first;
      end else begin
         bundle.pair = 1'b1;
         if (min_pos_in <= max_pos_in) begin
            bundle.first  = '{INDEX_BITS'(min_pos_in), run_min_in, 1'b0, 1'b0};
            bundle.second = '{INDEX_BITS'(max_pos_in), run_max_in, 1'b1, fend};
         end else begin
            bundle.first  = '{INDEX_BITS'(max_pos_in), run_max_in, 1'b0, 1'b0};
            bundle.second = '{INDEX_BITS'(min_pos_in), run_min_in, 1'b1, fend};
         end
      end
   end

   assign head        = queue_ff[rd_ptr_ff];
   assign head_point  = sub_ff ? head.second : head.first;
   assign rsp_valid   = (count_ff != 2'd0);
   assign pop_out     = rsp_valid && rsp_ready;
   assign bundle_done = pop_out && (!head.pair || sub_ff);

   assign rsp_bin_index   = head_point.bin_index;
   assign rsp_point_value = head_point.point_value;
   assign rsp_run_last    = head_point.run_last;
   assign rsp_frame_end   = head_point.frame_end;

   always_comb begin
      sub_in    = sub_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(bundle_done);
      if (pop_out) begin
         sub_in = !bundle_done;
      end
      if (bundle_done) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff     <= BIN_REG_BITS'(RST_BIN_COUNT);
         pixel_columns_ff <= COL_REG_BITS'(RST_PIXEL_COLUMNS);
         div_start_ff     <= 1'b0;
         div_busy_ff      <= 1'b0;
         div_cnt_ff       <= '0;
         step_q_ff        <= BW'(RST_Q);
         step_r_ff        <= CW'(RST_R);
         bin_cnt_ff       <= '0;
         col_end_ff       <= '0;
         bnd_rem_ff       <= '0;
         count_ff         <= '0;
         rd_ptr_ff        <= 1'b0;
         wr_ptr_ff        <= 1'b0;
         sub_ff           <= 1'b0;
      end else begin
         bin_count_ff     <= bin_count_in;
         pixel_columns_ff <= pixel_columns_in;
         div_start_ff     <= div_start_in;
         div_busy_ff      <= div_busy_in;
         div_cnt_ff       <= div_cnt_in;
         step_q_ff        <= step_q_in;
         step_r_ff        <= step_r_in;
         bin_cnt_ff       <= bin_cnt_in;
         col_end_ff       <= col_end_in;
         bnd_rem_ff       <= bnd_rem_in;
         count_ff         <= count_in;
         rd_ptr_ff        <= rd_ptr_in;
         wr_ptr_ff        <= wr_ptr_in;
         sub_ff           <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_den_ff <= div_den_in;
      run_min_ff <= run_min_in;
      run_max_ff <= run_max_in;
      min_pos_ff <= min_pos_in;
      max_pos_ff <= max_pos_in;
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue overfilled");

   a_no_take_in_div: assert property (@(posedge clock) disable iff (reset)
      take |-> !div_busy_ff && !div_start_ff)
      else $error("request accepted during step division");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      pop_out && !rsp_run_last |=> rsp_valid)
      else $error("second point of a column lost");

   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("frame end on a point that is not last");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mmcd_pkg::*;

   class decimation_scoreboard;
      logic [BIN_REG_BITS-1:0]       bin_count;
      logic [COL_REG_BITS-1:0]       pixel_columns;
      int unsigned                   bin_pos;
      int unsigned                   column_end;
      int unsigned                   carry;
      int unsigned                   step_quot;
      int unsigned                   step_rem;
      logic signed [SAMPLE_BITS-1:0] level_min;
      logic signed [SAMPLE_BITS-1:0] level_max;
      logic [INDEX_BITS-1:0]         pos_min;
      logic [INDEX_BITS-1:0]         pos_max;
      point_type                     pending_points[$];
      int unsigned                   mismatches;

      function new();
         bin_count = BIN_REG_BITS'(RST_BIN_COUNT);
         pixel_columns = COL_REG_BITS'(RST_PIXEL_COLUMNS);
         column_end = 0;
         carry = 0;
         level_min = '0;
         level_max = '0;
         pos_min = '0;
         pos_max = '0;
         mismatches = 0;
         recompute_steps();
      endfunction

      function int unsigned eff_bins();
         return (bin_count > DEF_MAX_BINS) ? DEF_MAX_BINS : bin_count;
      endfunction

      function int unsigned eff_cols();
         return (pixel_columns > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : pixel_columns;
      endfunction

      function bit active();
         return eff_bins() != 0 && eff_cols() != 0;
      endfunction

      function void recompute_steps();
         if (eff_cols() == 0) begin
            step_quot = 0;
            step_rem = 0;
         end else begin
            step_quot = eff_bins() / eff_cols();
            step_rem = eff_bins() % eff_cols();
         end
         bin_pos = 0;
      endfunction

      function void note_register(csr_reg_type which, logic [CSR_DATA_BITS-1:0] value);
         case (which)
            REG_BIN_COUNT: bin_count = value[BIN_REG_BITS-1:0];
            REG_PIXEL_COLUMNS: pixel_columns = value[COL_REG_BITS-1:0];
            default: ;
         endcase
         recompute_steps();
      endfunction

      function void add_point(int unsigned idx, logic signed [SAMPLE_BITS-1:0] level,
                              logic last, logic fend);
         point_type p;
         p.bin_index = INDEX_BITS'(idx);
         p.point_value = level;
         p.run_last = last;
         p.frame_end = fend;
         pending_points = {pending_points, p};
      endfunction

      function void take_sample(logic signed [SAMPLE_BITS-1:0] level);
         int unsigned nbins;
         int unsigned ncols;
         int unsigned idx;
         logic        frame_done;
         nbins = eff_bins();
         ncols = eff_cols();
         if (nbins == 0 || ncols == 0)
            return;
         idx = bin_pos;
         frame_done = (idx + 1 >= nbins);
         bin_pos = frame_done ? 0 : idx + 1;
         if (2 * ncols >= nbins) begin
            add_point(idx, level, 1'b1, frame_done);
            return;
         end
         if (idx == 0 || idx >= column_end) begin
            if (idx == 0) begin
               column_end = step_quot;
               carry = step_rem;
            end else begin
               column_end += step_quot;
               carry += step_rem;
               if (carry >= ncols) begin
                  carry -= ncols;
                  column_end++;
               end
            end
            level_min = level;
            level_max = level;
            pos_min = INDEX_BITS'(idx);
            pos_max = INDEX_BITS'(idx);
         end else begin
            if (level < level_min) begin
               level_min = level;
               pos_min = INDEX_BITS'(idx);
            end
            if (level > level_max) begin
               level_max = level;
               pos_max = INDEX_BITS'(idx);
            end
         end
         if (idx + 1 != column_end && !frame_done)
            return;
         if (pos_min <= pos_max) begin
            add_point(pos_min, level_min, 1'b0, 1'b0);
            add_point(pos_max, level_max, 1'b1, frame_done);
         end else begin
            add_point(pos_max, level_max, 1'b0, 1'b0);
            add_point(pos_min, level_min, 1'b1, frame_done);
         end
      endfunction

      task report_mismatch(string what);
         $display("%0t mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_point(point_type got);
         point_type want;
         if (pending_points.size() == 0) begin
            report_mismatch($sformatf("unexpected point, bin %0d", got.bin_index));
            return;
         end
         want = pending_points.pop_front();
         if (got.bin_index !== want.bin_index)
            report_mismatch($sformatf("bin_index %0d, want %0d",
                                      got.bin_index, want.bin_index));
         if (got.point_value !== want.point_value)
            report_mismatch($sformatf("point_value %0d, want %0d (bin %0d)",
                                      got.point_value, want.point_value, want.bin_index));
         if (got.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b (bin %0d)",
                                      got.run_last, want.run_last, want.bin_index));
         if (got.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, want %b (bin %0d)",
                                      got.frame_end, want.frame_end, want.bin_index));
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [INDEX_BITS-1:0]         rsp_bin_index;
   logic signed [SAMPLE_BITS-1:0] rsp_point_value;
   logic                          rsp_run_last;
   logic                          rsp_frame_end;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      paddr = '0;
   logic [CSR_DATA_BITS-1:0]      pwdata = '0;
   logic [CSR_DATA_BITS-1:0]      prdata;
   logic                          pready;

   decimation_scoreboard sb;
   bit                   idle_gaps = 1'b1;

   minmax_column_decimator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_point_value  (rsp_point_value),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_end    (rsp_frame_end),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_point(point_type'{rsp_bin_index, rsp_point_value,
                                    rsp_run_last, rsp_frame_end});
      rsp_ready <= !idle_gaps || ($urandom_range(99) >= 35);
   end

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] level);
      while (idle_gaps && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_value <= level;
      do @(posedge clock); while (!req_ready);
      sb.take_sample(level);
   endtask

   // hold requests until every point is out, then let the pipeline go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_points.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type which, input logic [CSR_DATA_BITS-1:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {which, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.note_register(which, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_level();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return SAMPLE_BITS'($urandom_range(4)) - 16'sd2;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int unsigned sent;
      int unsigned phase;
      int unsigned roll;
      int unsigned which;
      int unsigned nb;
      int unsigned nc;
      int unsigned count;
      sb = new();
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset step: four bins per column, extremes and a tie on the maximum
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      send_sample(16'sh0000);
      send_sample(16'sh7fff);
      // maximum ahead of minimum
      send_sample(16'sd5);
      send_sample(16'sd5);
      send_sample(-16'sd1);
      send_sample(-16'sd1);
      settle();

      // flat column: the same bin is both minimum and maximum
      write_reg(REG_BIN_COUNT, 32'd3);
      write_reg(REG_PIXEL_COLUMNS, 32'd1);
      repeat (3) send_sample(16'sh0100);
      settle();

      // uneven split: columns of two and three bins
      write_reg(REG_BIN_COUNT, 32'd5);
      write_reg(REG_PIXEL_COLUMNS, 32'd2);
      send_sample(16'sd3);
      send_sample(-16'sd3);
      send_sample(16'sd7);
      send_sample(16'sd7);
      send_sample(-16'sd8);
      settle();

      // pass-through
      write_reg(REG_BIN_COUNT, 32'd4);
      repeat (4) send_sample(pick_level());
      settle();

      // zero registers: drop every request
      write_reg(REG_BIN_COUNT, 32'd0);
      repeat (2) send_sample(pick_level());
      settle();
      write_reg(REG_BIN_COUNT, 32'd4);
      write_reg(REG_PIXEL_COLUMNS, 32'd0);
      send_sample(pick_level());
      settle();

      phase = 0;
      while (sent < 1550) begin
         roll = $urandom_range(99);
         case (phase)
            0: begin
               nb = 131071;
               nc = 8191;
            end
            1: begin
               nb = 65536;
               nc = 4096;
            end
            2: begin
               nb = 1;
               nc = 1;
            end
            3: begin
               nb = 2;
               nc = 1;
            end
            default: begin
               if (roll < 6) begin
                  if ($urandom_range(1)) begin
                     nb = 0;
                     nc = $urandom_range(1, 24);
                  end else begin
                     nb = $urandom_range(1, 96);
                     nc = 0;
                  end
               end else if (roll < 16) begin
                  nb = $urandom_range(4096, 131071);
                  nc = $urandom_range(1, 8191);
               end else begin
                  nb = $urandom_range(1, 96);
                  nc = $urandom_range(1, 24);
               end
            end
         endcase
         which = (phase < 4 || roll < 6) ? 2 : $urandom_range(2);
         if (which != 1)
            write_reg(REG_BIN_COUNT, {15'($urandom), 17'(nb)});
         if (which != 0)
            write_reg(REG_PIXEL_COLUMNS, {19'($urandom), 13'(nc)});

         if (!sb.active())
            count = $urandom_range(1, 4);
         else if (sb.eff_bins() >= 4096)
            count = $urandom_range(50, 250);
         else
            count = $urandom_range(1, (3 * sb.eff_bins() + 4 > 160) ?
                                       160 : 3 * sb.eff_bins() + 4);

         repeat (count) begin
            send_sample(pick_level());
            if (sb.active())
               sent++;
            idle_gaps = !(sent >= 700 && sent < 1000);
         end
         settle();
         phase++;
      end

      idle_gaps = 1'b1;
      settle();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
